>>> sv/sac_pkg.sv
// Shared types and constants of the set-associative cache lookup and replacement block.
`default_nettype none
package sac_pkg;

  localparam int WAYS       = 4;
  localparam int SETS       = 64;
  localparam int ADDR_WIDTH = 32;
  localparam int TAG_W      = 32;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int AGE_W      = 8;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  typedef enum logic [1:0] {
    REG_POLICY      = 2'd0,
    REG_OFFSET_BITS = 2'd1,
    REG_INDEX_BITS  = 2'd2,
    REG_SEED        = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    POL_RANDOM = 2'd0,
    POL_LRU    = 2'd1,
    POL_PLRU   = 2'd2,
    POL_NONE   = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    OUT_HIT    = 2'd0,
    OUT_FILL   = 2'd1,
    OUT_EVICT  = 2'd2,
    OUT_NOFILL = 2'd3
  } outcome_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // One memory row holds the whole state of a set.
  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0]            valid;
    logic [WAYS-1:0]            dirty;
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            plru;
  } set_row_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [WAY_W-1:0]   way;
    logic               vdirty;
    logic [TAG_W-1:0]   vtag;
  } sac_result_t;

endpackage
`default_nettype wire

>>> sv/sac_update.sv
// Hit detection, victim selection and row update for one set of the cache.
`default_nettype none
module sac_update (
  input  sac_pkg::set_row_t    row_in,
  input  logic [sac_pkg::TAG_W-1:0] req_tag,
  input  logic                 store,
  input  sac_pkg::policy_t     policy,
  input  logic [15:0]          lfsr,
  output sac_pkg::set_row_t    row_out,
  output sac_pkg::sac_result_t result,
  output logic [15:0]          lfsr_out,
  output logic                 lfsr_adv
);
  import sac_pkg::*;

  logic                         hit;
  logic [WAY_W-1:0]             hit_way;
  logic [WAYS-1:0][AGE_W-1:0]   aged;
  logic                         have_empty;
  logic [WAY_W-1:0]             empty_way;
  logic                         have_best;
  logic [WAY_W-1:0]             best_way;
  logic [AGE_W-1:0]             best_age;
  logic [WAY_W-1:0]             free_way;
  logic [WAY_W-1:0]             victim;

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  assign lfsr_out = lfsr_next(lfsr);

  // Lowest matching way wins, as in a priority search from way 0.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_in.valid[w] && row_in.tag[w] == req_tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (row_in.valid[w] && row_in.age[w] != AGE_MAX) begin
        aged[w] = row_in.age[w] + AGE_W'(1);
      end else begin
        aged[w] = row_in.age[w];
      end
    end
  end

  // The oldest valid way, ties going to the higher way; the highest empty way;
  // the highest way whose pseudo-LRU bit is clear.
  always_comb begin
    have_empty = 1'b0;
    empty_way  = '0;
    have_best  = 1'b0;
    best_way   = '0;
    best_age   = '0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!row_in.valid[w]) begin
        have_empty = 1'b1;
        empty_way  = WAY_W'(w);
      end else if (!have_best || row_in.age[w] >= best_age) begin
        have_best = 1'b1;
        best_way  = WAY_W'(w);
        best_age  = row_in.age[w];
      end
      if (!row_in.plru[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    row_out  = row_in;
    result   = '0;
    lfsr_adv = 1'b0;
    victim   = '0;
    if (hit) begin
      result.outcome = OUT_HIT;
      result.way     = hit_way;
      if (store) begin
        row_out.dirty[hit_way] = 1'b1;
      end
      case (policy)
        POL_LRU: begin
          row_out.age          = aged;
          row_out.age[hit_way] = AGE_W'(1);
        end
        POL_PLRU: begin
          row_out.plru[hit_way] = 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      case (policy)
        POL_RANDOM: begin
          lfsr_adv = 1'b1;
          victim   = WAY_W'(lfsr_out % WAYS);
        end
        POL_LRU: begin
          victim              = have_empty ? empty_way : best_way;
          row_out.age         = aged;
          row_out.age[victim] = AGE_W'(1);
        end
        POL_PLRU: begin
          if (&row_in.plru) begin
            row_out.plru = '0;
            victim       = '0;
          end else begin
            victim = free_way;
          end
          row_out.plru[victim] = 1'b1;
        end
        default: begin
        end
      endcase
      if (policy == POL_NONE) begin
        result.outcome = OUT_NOFILL;
      end else begin
        result.way = victim;
        if (row_in.valid[victim]) begin
          result.outcome = OUT_EVICT;
          result.vdirty  = row_in.dirty[victim];
          result.vtag    = row_in.tag[victim];
        end else begin
          result.outcome = OUT_FILL;
        end
        row_out.tag[victim]   = req_tag;
        row_out.valid[victim] = 1'b1;
        row_out.dirty[victim] = store;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/set_assoc_cache_lookup_replace.sv
// Top level of the set-associative cache tag lookup and replacement block.
// For each request the set's row is read from a single synchronous memory
// when the request is accepted, and the updated row is written back when the
// result enters the output register. A new request is taken in the cycle
// after that, so requests do not overlap, and a stalled result side holds
// the block busy. A row that has not been written since reset reads as an
// empty set, so no clearing pass is needed.
// Replacement is random (16-bit LFSR), true LRU by saturating age counters,
// bit pseudo-LRU or none (no fill), selected by a register on the APB port.
`default_nettype none
module set_assoc_cache_lookup_replace (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        req_type,
  input  logic [31:0] address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  outcome,
  output logic [sac_pkg::WAY_W-1:0] way_used,
  output logic        victim_dirty,
  output logic [31:0] victim_tag
);
  import sac_pkg::*;

  policy_t      replace_policy;
  logic [3:0]   offset_bits;
  logic [2:0]   index_bits;
  logic [15:0]  random_seed;
  logic [15:0]  lfsr;

  state_t       state;
  state_t       state_next;
  logic         req_accept;
  logic         done;
  logic         cfg_write;

  logic         req_store;
  logic [TAG_W-1:0] req_tag;
  logic [SET_W-1:0] req_set;
  logic [SET_W-1:0] set_mask;
  logic [4:0]       tag_shift;
  logic [ADDR_WIDTH-1:0] addr_shifted;

  set_row_t     set_mem [SETS];
  logic [SETS-1:0] row_written;
  set_row_t     rd_data;
  logic         rd_ok;
  set_row_t     row_in;
  set_row_t     row_out;
  sac_result_t  result;
  logic [15:0]  lfsr_out;
  logic         lfsr_adv;
  sac_result_t  rsp;

  function automatic logic [15:0] seed_value(input logic [15:0] s);
    return (s == 16'd0) ? 16'd1 : s;
  endfunction

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_POLICY:      prdata = {30'd0, replace_policy};
      REG_OFFSET_BITS: prdata = {28'd0, offset_bits};
      REG_INDEX_BITS:  prdata = {29'd0, index_bits};
      REG_SEED:        prdata = {16'd0, random_seed};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replace_policy <= POL_LRU;
      offset_bits    <= 4'd6;
      index_bits     <= 3'd6;
      random_seed    <= SEED_RESET;
      lfsr           <= seed_value(SEED_RESET);
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_POLICY:      replace_policy <= policy_t'(pwdata[1:0]);
        REG_OFFSET_BITS: offset_bits    <= pwdata[3:0];
        REG_INDEX_BITS:  index_bits     <= pwdata[2:0];
        REG_SEED: begin
          random_seed <= pwdata[15:0];
          lfsr        <= seed_value(pwdata[15:0]);
        end
        default: begin
        end
      endcase
    end else if (done && lfsr_adv) begin
      lfsr <= lfsr_out;
    end
  end

  // Address split: the set index wraps to the number of sets.
  assign set_mask     = SET_W'((8'd1 << index_bits) - 8'd1);
  assign addr_shifted = address >> offset_bits;
  assign tag_shift    = {1'b0, offset_bits} + {2'b00, index_bits};

  // Sequencer.
  assign req_stall  = rst || (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!rsp_valid || !rsp_stall) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_store <= req_type;
      req_set   <= addr_shifted[SET_W-1:0] & set_mask;
      req_tag   <= TAG_W'(address >> tag_shift);
    end
  end

  // Set memory: read on acceptance, written back when the request completes.
  always_ff @(posedge clk) begin
    if (done) begin
      set_mem[req_set] <= row_out;
    end
    if (req_accept) begin
      rd_data <= set_mem[addr_shifted[SET_W-1:0] & set_mask];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_written <= '0;
      rd_ok       <= 1'b0;
    end else begin
      if (done) begin
        row_written[req_set] <= 1'b1;
      end
      if (req_accept) begin
        rd_ok <= row_written[addr_shifted[SET_W-1:0] & set_mask];
      end
    end
  end

  // A row never written holds an empty set.
  always_comb begin
    row_in = rd_data;
    if (!rd_ok) begin
      row_in.valid = '0;
      row_in.dirty = '0;
      row_in.age   = '0;
      row_in.plru  = '0;
    end
  end

  sac_update u_update (
    .row_in   (row_in),
    .req_tag  (req_tag),
    .store    (req_store),
    .policy   (replace_policy),
    .lfsr     (lfsr),
    .row_out  (row_out),
    .result   (result),
    .lfsr_out (lfsr_out),
    .lfsr_adv (lfsr_adv)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp <= result;
    end
  end

  assign outcome      = rsp.outcome;
  assign way_used     = rsp.way;
  assign victim_dirty = rsp.vdirty;
  assign victim_tag   = rsp.vtag;

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (rst)
    req_accept |=> state == ST_LOOKUP)
    else $error("accepted request did not start a lookup");

  a_rsp_from_lookup: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_LOOKUP)
    else $error("result appeared without a completed lookup");

  a_no_victim_on_non_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.outcome != OUT_EVICT |-> !rsp.vdirty && rsp.vtag == '0)
    else $error("victim reported without an eviction");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (rst)
    lfsr != 16'd0)
    else $error("random LFSR locked at zero");
`endif

endmodule
`default_nettype wire
